/* hdl/radix_digit_converter_assert.svh */
// Assertion macros for the converter's datapath.
// They rely on the clock clk and the active-low reset arst_n of the module that uses them.
`ifndef RADIX_DIGIT_CONVERTER_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_ASSERT_SVH

// A property that must hold at every clock edge out of reset.
`define RDC_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("radix converter invariant violated");

// A consequence that must hold in the same cycle as its cause.
`define RDC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("radix converter implication violated");

// A consequence that must hold in the cycle after its cause.
`define RDC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("radix converter next-cycle check violated");

`endif

/* hdl/rdc_pkg.sv */
package rdc_pkg;

	localparam int VALUE_BITS = 31;
	localparam int MAX_DIGITS = 32;

	localparam int RADIX_W = 5;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W  = 7;

	localparam int RADIX_MIN   = 2;
	localparam int RADIX_MAX   = 16;
	localparam int RADIX_RESET = 10;

	// The divider retires this many dividend bits per cycle.
	localparam int CHUNK_BITS  = 8;
	localparam int CHUNKS      = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
	localparam int WORK_W      = CHUNKS * CHUNK_BITS;
	localparam int CHUNK_CNT_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

	localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
	localparam int ADDR_W = $clog2(MAX_DIGITS);

	localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0]  CHAR_A    = 7'h41;
	localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;
	localparam logic [CHAR_W-1:0]  TEN       = 7'd10;

	typedef struct packed {
		logic load;
		logic div_step;
		logic wr_digit;
		logic emit_step;
	} dp_cmd_t;

	typedef struct packed {
		logic chunk_last;
		logic more_digits;
		logic emit_last;
	} dp_sts_t;

	function automatic logic [CHAR_W-1:0] char_of(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] res;
		if (d > DIGIT_NINE) begin
			res = CHAR_A + CHAR_W'(d) - TEN;
		end else begin
			res = CHAR_ZERO + CHAR_W'(d);
		end
		return res;
	endfunction

	function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] v);
		logic [RADIX_W-1:0] res;
		if (v < RADIX_W'(RADIX_MIN)) begin
			res = RADIX_W'(RADIX_MIN);
		end else if (v > RADIX_W'(RADIX_MAX)) begin
			res = RADIX_W'(RADIX_MAX);
		end else begin
			res = v;
		end
		return res;
	endfunction

endpackage

/* hdl/rdc_ram.sv */
module rdc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/rdc_ctrl.sv */
module rdc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  rdc_pkg::dp_sts_t sts,
	output rdc_pkg::dp_cmd_t cmd,
	output logic             busy
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_WR   = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.chunk_last) begin
					state_nxt = ST_WR;
				end
			end
			ST_WR: begin
				cmd.wr_digit = 1'b1;
				state_nxt    = sts.more_digits ? ST_DIV : ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit_step = 1'b1;
				if (sts.emit_last) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

/* hdl/rdc_datapath.sv */
module rdc_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rdc_pkg::dp_cmd_t                    cmd,
	output rdc_pkg::dp_sts_t                    sts,
	input  logic [rdc_pkg::VALUE_BITS-1:0]      value,
	input  logic                                radix_we,
	input  logic [rdc_pkg::RADIX_W-1:0]         radix_wdata,
	output logic [rdc_pkg::CHAR_W-1:0]          digit_char,
	output logic                                last_digit,
	output logic                                digit_valid
);

	`include "radix_digit_converter_assert.svh"

	logic [rdc_pkg::RADIX_W-1:0]     radix_q;
	logic [rdc_pkg::WORK_W-1:0]      work_q;
	logic [rdc_pkg::WORK_W-1:0]      work_nxt;
	logic [rdc_pkg::DIGIT_W-1:0]     rem_q;
	logic [rdc_pkg::DIGIT_W-1:0]     rem_nxt;
	logic [rdc_pkg::CHUNK_CNT_W-1:0] chunk_q;
	logic [rdc_pkg::CNT_W-1:0]       cnt_q;
	logic [rdc_pkg::CNT_W-1:0]       rd_idx;
	logic [rdc_pkg::DIGIT_W-1:0]     ram_rdata;
	logic                            vld_s1;
	logic                            last_s1;

	// Long division of the top chunk of the work word by the radix, one bit per step.
	always_comb begin
		logic [rdc_pkg::CHUNK_BITS-1:0] chunk;
		logic [rdc_pkg::CHUNK_BITS-1:0] qbits;
		logic [rdc_pkg::DIGIT_W-1:0]    r;
		logic [rdc_pkg::RADIX_W-1:0]    t;
		chunk = work_q[rdc_pkg::WORK_W-1 -: rdc_pkg::CHUNK_BITS];
		qbits = '0;
		r     = rem_q;
		for (int i = rdc_pkg::CHUNK_BITS - 1; i >= 0; i--) begin
			t = {r, chunk[i]};
			if (t >= radix_q) begin
				t        = t - radix_q;
				qbits[i] = 1'b1;
			end
			r = t[rdc_pkg::DIGIT_W-1:0];
		end
		rem_nxt  = r;
		work_nxt = (work_q << rdc_pkg::CHUNK_BITS) | rdc_pkg::WORK_W'(qbits);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= rdc_pkg::RADIX_W'(rdc_pkg::RADIX_RESET);
			work_q  <= '0;
			rem_q   <= '0;
			chunk_q <= '0;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			if (radix_we) begin
				radix_q <= rdc_pkg::sat_radix(radix_wdata);
			end
			if (cmd.load) begin
				work_q  <= rdc_pkg::WORK_W'(value);
				rem_q   <= '0;
				chunk_q <= '0;
				cnt_q   <= '0;
			end
			if (cmd.div_step) begin
				work_q  <= work_nxt;
				rem_q   <= rem_nxt;
				chunk_q <= chunk_q + 1'b1;
			end
			if (cmd.wr_digit) begin
				rem_q   <= '0;
				chunk_q <= '0;
				cnt_q   <= cnt_q + 1'b1;
			end
			if (cmd.emit_step) begin
				cnt_q <= rd_idx;
			end
			vld_s1  <= cmd.emit_step;
			last_s1 <= cmd.emit_step && sts.emit_last;
		end
	end

	assign rd_idx = cnt_q - 1'b1;

	rdc_ram #(
		.WIDTH (rdc_pkg::DIGIT_W),
		.DEPTH (rdc_pkg::MAX_DIGITS)
	) u_store (
		.clk   (clk),
		.we    (cmd.wr_digit),
		.waddr (cnt_q[rdc_pkg::ADDR_W-1:0]),
		.wdata (rem_q),
		.re    (cmd.emit_step),
		.raddr (rd_idx[rdc_pkg::ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	assign sts.chunk_last  = (chunk_q == rdc_pkg::CHUNK_CNT_W'(rdc_pkg::CHUNKS - 1));
	assign sts.more_digits = (work_q != '0) &&
		(cnt_q < rdc_pkg::CNT_W'(rdc_pkg::MAX_DIGITS - 1));
	assign sts.emit_last   = (cnt_q == rdc_pkg::CNT_W'(1));

	assign digit_char  = rdc_pkg::char_of(ram_rdata);
	assign last_digit  = last_s1;
	assign digit_valid = vld_s1;

	`RDC_ASSERT_ALWAYS(a_radix_range, radix_q >= rdc_pkg::RADIX_W'(rdc_pkg::RADIX_MIN) && radix_q <= rdc_pkg::RADIX_W'(rdc_pkg::RADIX_MAX))
	`RDC_ASSERT_IMP(a_rem_below_radix, cmd.div_step, rdc_pkg::RADIX_W'(rem_q) < radix_q)
	`RDC_ASSERT_IMP(a_write_in_range, cmd.wr_digit, cnt_q < rdc_pkg::CNT_W'(rdc_pkg::MAX_DIGITS))
	`RDC_ASSERT_NXT(a_store_drained, cmd.emit_step && sts.emit_last, cnt_q == '0)

endmodule

/* hdl/radix_digit_converter.sv */
// Channel   Handshake           Payload
// command   start / busy        value[30:0]
// config    radix_we            radix_wdata[4:0]
// result    digit_valid strobe  digit_char[6:0], last_digit
//
// A value is taken when start is high and busy is low.
// Each digit takes four divider steps of eight dividend bits each and a write of the
// remainder to the digit store. Emission then reads one digit a cycle, and busy stays
// high until the read of the last digit.
// The last word is strobed in the first cycle with busy low, when a new value may be taken.
// Reset is asynchronous and active low; it sets the radix to ten and idles the sequencer.
// Result words are strobed for one cycle each and the receiver cannot stall them.
module radix_digit_converter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [rdc_pkg::VALUE_BITS-1:0] value,
	input  logic                           radix_we,
	input  logic [rdc_pkg::RADIX_W-1:0]    radix_wdata,
	output logic                           digit_valid,
	output logic [rdc_pkg::CHAR_W-1:0]     digit_char,
	output logic                           last_digit
);

	// The controller sequences division steps, digit writes and emission reads;
	// the datapath owns the radix register, the divider, the digit count and the store.
	rdc_pkg::dp_cmd_t cmd;
	rdc_pkg::dp_sts_t sts;

	// Sequencer: idle, divide by chunks, write the remainder as a digit, then read the
	// digits back from the most significant one down.
	rdc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Datapath: a zero value still runs one division and yields the single digit zero.
	// The store read is registered, so each word appears in the cycle after its read.
	rdc_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.value       (value),
		.radix_we    (radix_we),
		.radix_wdata (radix_wdata),
		.digit_char  (digit_char),
		.last_digit  (last_digit),
		.digit_valid (digit_valid)
	);

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

// Bench for the radix digit converter.
//
// A value goes in on the start/busy command port and comes back as a train of
// ASCII digit words, most significant first, with last_digit marking the final
// word. The bench keeps its own model of the converter: the radix register and a
// division loop that produces the digits the block should emit. Every accepted
// value is converted by that model at the edge where it is accepted. The words
// land in a queue, and a checker pops one entry per strobed result word.
//
// The tests run in turn. Reset default radix and directed values come first,
// then the corner values in the smallest and largest bases. Saturation of
// out-of-range radix writes follows. Last is a long random run over several
// radix settings. The radix register is only rewritten while the converter is
// idle and every pending digit has been seen.
module tb;

	localparam int VALUE_BITS  = rdc_pkg::VALUE_BITS;
	localparam int MAX_DIGITS  = rdc_pkg::MAX_DIGITS;
	localparam int RADIX_W     = rdc_pkg::RADIX_W;
	localparam int DIGIT_W     = rdc_pkg::DIGIT_W;
	localparam int CHAR_W      = rdc_pkg::CHAR_W;
	localparam int RADIX_MIN   = rdc_pkg::RADIX_MIN;
	localparam int RADIX_MAX   = rdc_pkg::RADIX_MAX;
	localparam int RADIX_RESET = rdc_pkg::RADIX_RESET;

	// ASCII codes of the two digit ranges.
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'h41;

	// Cycles without any accepted word before the run is declared hung. The longest
	// quiet stretch is a sender pause or the division phase of a 31-digit base-2
	// value, so this leaves a wide margin.
	localparam int HANG_LIMIT = 2000;

	localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic last;
	} digit_word_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [VALUE_BITS-1:0] value;
	logic radix_we;
	logic [RADIX_W-1:0] radix_wdata;
	logic digit_valid;
	logic [CHAR_W-1:0] digit_char;
	logic last_digit;

	// Bench copy of the radix register and the digit words still owed by the block.
	logic [RADIX_W-1:0] radix_setting;
	digit_word_t pending_digits[$];

	int error_count;
	int quiet_cycles;
	// While set, the sender never pauses between values.
	bit back_to_back;

	radix_digit_converter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.radix_we   (radix_we),
		.radix_wdata(radix_wdata),
		.digit_valid(digit_valid),
		.digit_char (digit_char),
		.last_digit (last_digit)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mirrors the register write: anything below two becomes two and anything above
	// sixteen becomes sixteen.
	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] w);
		logic [RADIX_W-1:0] r;
		r = w;
		if (w < RADIX_W'(RADIX_MIN))
			r = RADIX_W'(RADIX_MIN);
		else if (w > RADIX_W'(RADIX_MAX))
			r = RADIX_W'(RADIX_MAX);
		return r;
	endfunction

	// Converts one accepted value in the current base. The digits are produced least
	// significant first by repeated division. They are then queued most significant
	// first, which is the order the block emits them. Zero yields a single '0'.
	function automatic void predict_digits(input logic [VALUE_BITS-1:0] v);
		logic [DIGIT_W-1:0] digits [MAX_DIGITS];
		logic [VALUE_BITS-1:0] quotient;
		logic [DIGIT_W-1:0] d;
		digit_word_t w;
		int n;
		quotient = v;
		n = 0;
		if (quotient == '0) begin
			digits[0] = '0;
			n = 1;
		end
		while (quotient != '0 && n < MAX_DIGITS) begin
			digits[n] = DIGIT_W'(quotient % radix_setting);
			n++;
			quotient = quotient / radix_setting;
		end
		for (int k = n; k > 0; k--) begin
			d = digits[k-1];
			if (d > DIGIT_W'(9))
				w.ch = ASCII_UPPER_A + CHAR_W'(d) - CHAR_W'(10);
			else
				w.ch = ASCII_ZERO + CHAR_W'(d);
			w.last = (k == 1);
			pending_digits.push_back(w);
		end
	endfunction

	// Result checker and hang watchdog. Both look at the outputs as they stood just
	// before the rising edge.
	always @(posedge clk) begin
		digit_word_t exp_word;
		if (arst_n) begin
			if ((start && !busy) || digit_valid)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (digit_valid) begin
				if (pending_digits.size() == 0) begin
					$display("%0t: unexpected digit word char=%h last=%b",
						$realtime, digit_char, last_digit);
					error_count++;
				end else begin
					exp_word = pending_digits.pop_front();
					if (digit_char !== exp_word.ch) begin
						$display("%0t: digit_char mismatch: expected %h, actual %h",
							$realtime, exp_word.ch, digit_char);
						error_count++;
					end
					if (last_digit !== exp_word.last) begin
						$display("%0t: last_digit mismatch: expected %b, actual %b",
							$realtime, exp_word.last, last_digit);
						error_count++;
					end
				end
			end
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("%0t: timeout, no word accepted for %0d cycles",
					$realtime, HANG_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Sends one value. It is entered and left at a falling edge. Outside the
	// back-to-back stretch, about one value in five is preceded by a pause. The
	// pause is usually short but now and then long enough to end anywhere inside
	// the previous conversion. start is left high on return, so the next call can
	// drive its value at once. Otherwise the caller drops start.
	task automatic send_value(input logic [VALUE_BITS-1:0] v);
		int gap;
		if (!back_to_back && $urandom_range(0, 99) < 20) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 6);
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		value = v;
		do
			@(posedge clk);
		while (busy);
		predict_digits(v);
		@(negedge clk);
	endtask

	// Lets every owed digit arrive and the converter go idle, then writes the radix
	// register. A short pause after the last digit covers any tail of the emit stage.
	task automatic write_radix(input logic [RADIX_W-1:0] w);
		start = 1'b0;
		while (pending_digits.size() != 0 || busy)
			@(negedge clk);
		repeat (2) @(negedge clk);
		radix_we = 1'b1;
		radix_wdata = w;
		@(negedge clk);
		radix_we = 1'b0;
		radix_wdata = $urandom_range(0, 31);
		radix_setting = clamp_radix(w);
	endtask

	// Out of reset the base is ten; single digits, the first carry and the largest
	// value.
	task automatic test_reset_base();
		send_value('0);
		send_value(VALUE_BITS'(9));
		send_value(VALUE_BITS'(10));
		send_value(VALUE_MAX);
		start = 1'b0;
	endtask

	// Smallest and largest base: the longest digit train (31 ones in base 2),
	// an alternating bit pattern, a lone top bit, and every hex letter in base 16.
	task automatic test_base_extremes();
		write_radix(RADIX_W'(RADIX_MIN));
		send_value('0);
		send_value(VALUE_BITS'(1));
		send_value(VALUE_MAX);
		send_value(VALUE_BITS'(32'h5555_5555));
		send_value(VALUE_BITS'(32'h4000_0000));
		write_radix(RADIX_W'(RADIX_MAX));
		send_value(VALUE_BITS'(15));
		send_value(VALUE_BITS'(32'h2ABC_DEF0));
		send_value(VALUE_BITS'(32'h1234_5678));
		send_value(VALUE_MAX);
		send_value('0);
		start = 1'b0;
	endtask

	// Writes outside two to sixteen must clamp. Zero and one act as base 2;
	// seventeen and the all-ones code act as base 16. A plain in-range write follows.
	task automatic test_radix_clamp();
		write_radix(RADIX_W'(0));
		send_value(VALUE_BITS'(5));
		write_radix(RADIX_W'(1));
		send_value(VALUE_BITS'(6));
		write_radix(RADIX_W'(17));
		send_value(VALUE_BITS'(255));
		write_radix(RADIX_W'(31));
		send_value(VALUE_BITS'(32'h0FAC_E0FF));
		write_radix(RADIX_W'(3));
		send_value(VALUE_BITS'(80));
		send_value(VALUE_MAX);
		start = 1'b0;
	endtask

	// Values of assorted shapes: full-width random numbers, small numbers, runs of ones,
	// a single set bit at a random position, or random numbers cut to a random width.
	// Together they drive every input bit both ways and give digit trains of every length.
	function automatic logic [VALUE_BITS-1:0] random_value();
		logic [VALUE_BITS-1:0] v;
		int width;
		width = $urandom_range(0, VALUE_BITS - 1);
		case ($urandom_range(0, 4))
			0: v = VALUE_BITS'($urandom);
			1: v = VALUE_BITS'($urandom_range(0, 300));
			2: v = VALUE_MAX >> width;
			3: v = VALUE_BITS'(1) << width;
			default: v = VALUE_BITS'($urandom) >> width;
		endcase
		return v;
	endfunction

	// Random run: ten phases of 25 values. The first three phases use the two
	// extreme bases and the reset base; the rest use any code the register port
	// accepts, clamped ones included. Values 90 to 149 are sent without sender pauses.
	task automatic test_random_values();
		logic [RADIX_W-1:0] w;
		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0: w = RADIX_W'(RADIX_MIN);
				1: w = RADIX_W'(RADIX_MAX);
				2: w = RADIX_W'(RADIX_RESET);
				default: w = RADIX_W'($urandom_range(0, 31));
			endcase
			write_radix(w);
			for (int i = 0; i < 25; i++) begin
				back_to_back = (phase * 25 + i >= 90) && (phase * 25 + i < 150);
				send_value(random_value());
			end
			start = 1'b0;
		end
		back_to_back = 1'b0;
	endtask

	initial begin
		error_count = 0;
		quiet_cycles = 0;
		back_to_back = 1'b0;
		radix_setting = RADIX_W'(RADIX_RESET);
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		radix_we = 1'b0;
		radix_wdata = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_base();
		test_base_extremes();
		test_radix_clamp();
		test_random_values();

		// Drain everything still owed, then give the emit stage a little time to
		// show any word that should not be there.
		start = 1'b0;
		while (pending_digits.size() != 0 || busy)
			@(negedge clk);
		repeat (20) @(negedge clk);

		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
